>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros check on the rising edge
// of the given clock and stay quiet while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> rtl/cnv_pkg.sv
package cnv_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int COEF_BITS      = 8;
  localparam int DIM_BITS       = 11;
  localparam int KROW_BITS      = 3 * COEF_BITS;
  localparam int PIX_BITS       = 8;
  localparam int NUM_CH         = 4;
  localparam int ACC_BITS       = 21;
  localparam int KSUM_BITS      = 12;
  localparam int QUO_BITS       = 8;
  localparam int CFG_AW         = 5;
  localparam int APB_DW         = 32;

  localparam logic [DIM_BITS-1:0]  DIM_RESET   = 11'd1024;
  localparam logic [KROW_BITS-1:0] KTOP_RESET  = 24'h000000;
  localparam logic [KROW_BITS-1:0] KMID_RESET  = 24'h010000;
  localparam logic [KROW_BITS-1:0] KBOT_RESET  = 24'h000000;
  localparam logic [PIX_BITS-1:0]  PIX_MAX     = 8'd255;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_READ,
    S_ACC,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                op;
    logic [PIX_BITS-1:0] in_red;
    logic [PIX_BITS-1:0] in_green;
    logic [PIX_BITS-1:0] in_blue;
    logic [PIX_BITS-1:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] out_red;
    logic [PIX_BITS-1:0] out_green;
    logic [PIX_BITS-1:0] out_blue;
    logic [PIX_BITS-1:0] out_alpha;
    logic                frame_last;
  } out_item_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]             image_width;
    logic [DIM_BITS-1:0]             image_height;
    logic [2:0][KROW_BITS-1:0]       kernel;
  } cfg_t;

  typedef struct packed {
    logic       latch;
    logic       step;
    logic       rd;
    logic       acc;
    logic       prep;
    logic       div;
    logic       load;
    logic [1:0] tap_row;
    logic [1:0] tap_col;
    logic [2:0] bit_idx;
  } cmd_t;

  typedef struct packed {
    logic in_frame;
    logic is_flush;
    logic produce;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/cnv_stream_if.sv
interface cnv_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/cnv_regs.sv
module cnv_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cnv_pkg::CFG_AW-1:0]  paddr,
  input  logic [cnv_pkg::APB_DW-1:0]  pwdata,
  output logic [cnv_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output cnv_pkg::cfg_t               cfg,
  output logic                        geom_wr
);

  logic [cnv_pkg::DIM_BITS-1:0]  width_r;
  logic [cnv_pkg::DIM_BITS-1:0]  height_r;
  logic [cnv_pkg::KROW_BITS-1:0] ktop_r;
  logic [cnv_pkg::KROW_BITS-1:0] kmid_r;
  logic [cnv_pkg::KROW_BITS-1:0] kbot_r;
  cnv_pkg::reg_idx_t             idx;
  logic                          wr;

  assign idx    = cnv_pkg::reg_idx_t'(paddr[cnv_pkg::CFG_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign geom_wr = wr && ((idx == cnv_pkg::REG_IMAGE_WIDTH) ||
                          (idx == cnv_pkg::REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= cnv_pkg::DIM_RESET;
      height_r <= cnv_pkg::DIM_RESET;
      ktop_r   <= cnv_pkg::KTOP_RESET;
      kmid_r   <= cnv_pkg::KMID_RESET;
      kbot_r   <= cnv_pkg::KBOT_RESET;
    end else if (wr) begin
      unique case (idx)
        cnv_pkg::REG_IMAGE_WIDTH:   width_r  <= pwdata[cnv_pkg::DIM_BITS-1:0];
        cnv_pkg::REG_IMAGE_HEIGHT:  height_r <= pwdata[cnv_pkg::DIM_BITS-1:0];
        cnv_pkg::REG_KERNEL_TOP:    ktop_r   <= pwdata[cnv_pkg::KROW_BITS-1:0];
        cnv_pkg::REG_KERNEL_MIDDLE: kmid_r   <= pwdata[cnv_pkg::KROW_BITS-1:0];
        cnv_pkg::REG_KERNEL_BOTTOM: kbot_r   <= pwdata[cnv_pkg::KROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cnv_pkg::REG_IMAGE_WIDTH:   prdata = cnv_pkg::APB_DW'(width_r);
      cnv_pkg::REG_IMAGE_HEIGHT:  prdata = cnv_pkg::APB_DW'(height_r);
      cnv_pkg::REG_KERNEL_TOP:    prdata = cnv_pkg::APB_DW'(ktop_r);
      cnv_pkg::REG_KERNEL_MIDDLE: prdata = cnv_pkg::APB_DW'(kmid_r);
      cnv_pkg::REG_KERNEL_BOTTOM: prdata = cnv_pkg::APB_DW'(kbot_r);
      default:                    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.image_width  = width_r;
    cfg.image_height = height_r;
    cfg.kernel[0]    = ktop_r;
    cfg.kernel[1]    = kmid_r;
    cfg.kernel[2]    = kbot_r;
  end

endmodule

>>> rtl/cnv_ctrl.sv
module cnv_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cnv_pkg::sts_t sts,
  output cnv_pkg::cmd_t cmd
);

  cnv_pkg::state_t state_r, state_nxt;
  logic [1:0] tap_row_r, tap_row_nxt;
  logic [1:0] tap_col_r, tap_col_nxt;
  logic [2:0] bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cnv_pkg::S_IDLE;
      tap_row_r <= '0;
      tap_col_r <= '0;
      bit_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      tap_row_r <= tap_row_nxt;
      tap_col_r <= tap_col_nxt;
      bit_r     <= bit_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    tap_row_nxt = tap_row_r;
    tap_col_nxt = tap_col_r;
    bit_nxt     = bit_r;
    cmd         = '0;
    cmd.tap_row = tap_row_r;
    cmd.tap_col = tap_col_r;
    cmd.bit_idx = bit_r;
    in_ready    = (state_r == cnv_pkg::S_IDLE);
    unique case (state_r)
      cnv_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = cnv_pkg::S_STEP;
        end
      end
      cnv_pkg::S_STEP: begin
        // A flush that arrives before the frame is complete is dropped.
        if (sts.in_frame && sts.is_flush) begin
          state_nxt = cnv_pkg::S_IDLE;
        end else begin
          cmd.step = 1'b1;
          if (sts.produce) begin
            tap_row_nxt = '0;
            tap_col_nxt = '0;
            state_nxt   = cnv_pkg::S_READ;
          end else begin
            state_nxt = cnv_pkg::S_IDLE;
          end
        end
      end
      cnv_pkg::S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = cnv_pkg::S_ACC;
      end
      cnv_pkg::S_ACC: begin
        cmd.acc = 1'b1;
        if (tap_col_r == 2'd2) begin
          tap_col_nxt = '0;
          if (tap_row_r == 2'd2) begin
            state_nxt = cnv_pkg::S_PREP;
          end else begin
            tap_row_nxt = tap_row_r + 2'd1;
            state_nxt   = cnv_pkg::S_READ;
          end
        end else begin
          tap_col_nxt = tap_col_r + 2'd1;
          state_nxt   = cnv_pkg::S_READ;
        end
      end
      cnv_pkg::S_PREP: begin
        cmd.prep  = 1'b1;
        bit_nxt   = 3'd7;
        state_nxt = cnv_pkg::S_DIV;
      end
      cnv_pkg::S_DIV: begin
        cmd.div = 1'b1;
        if (bit_r == '0) begin
          state_nxt = cnv_pkg::S_DONE;
        end else begin
          bit_nxt = bit_r - 3'd1;
        end
      end
      cnv_pkg::S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = cnv_pkg::S_IDLE;
        end
      end
      default: state_nxt = cnv_pkg::S_IDLE;
    endcase
  end

endmodule

>>> rtl/cnv_dp.sv
`include "assert_macros.svh"

module cnv_dp #(
  parameter int MAX_WIDTH  = cnv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cnv_pkg::MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cnv_pkg::cfg_t      cfg,
  input  logic               geom_wr,
  input  cnv_pkg::cmd_t      cmd,
  output cnv_pkg::sts_t      sts,
  input  cnv_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output cnv_pkg::out_item_t out_item
);

  localparam int RING = 2 * MAX_WIDTH + 4;
  localparam int AW   = $clog2(RING);
  localparam int EW   = $clog2(MAX_WIDTH + 1);
  localparam int EH   = $clog2(MAX_HEIGHT + 1);
  localparam int NW   = $clog2(MAX_WIDTH * (MAX_HEIGHT + 2));
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int PB   = cnv_pkg::PIX_BITS;
  localparam int CB   = cnv_pkg::COEF_BITS;
  localparam int AB   = cnv_pkg::ACC_BITS;
  localparam int KB   = cnv_pkg::KSUM_BITS;
  localparam int NCH  = cnv_pkg::NUM_CH;
  localparam logic [AW+1:0] RING_X  = (AW+2)'(RING);
  localparam logic [AW+1:0] RING2_X = (AW+2)'(2 * RING);
  localparam logic [AW-1:0] RING_LAST = AW'(RING - 1);

  function automatic logic signed [CB-1:0] coef_sel(
    input logic [cnv_pkg::KROW_BITS-1:0] row,
    input logic [1:0]                    col
  );
    logic signed [CB-1:0] v;
    case (col)
      2'd0:    v = signed'(row[CB-1:0]);
      2'd1:    v = signed'(row[2*CB-1:CB]);
      default: v = signed'(row[3*CB-1:2*CB]);
    endcase
    return v;
  endfunction

  // Frame geometry as used: zero counts as one, oversize is limited.
  logic [EW-1:0]    eff_w;
  logic [EH-1:0]    eff_h;
  logic [NW-1:0]    total_r;
  logic signed [KB-1:0] ksum_c, ksum_r;

  always_comb begin
    if (cfg.image_width == '0) eff_w = EW'(1);
    else if (32'(cfg.image_width) > MAX_WIDTH) eff_w = EW'(MAX_WIDTH);
    else eff_w = EW'(cfg.image_width);
    if (cfg.image_height == '0) eff_h = EH'(1);
    else if (32'(cfg.image_height) > MAX_HEIGHT) eff_h = EH'(MAX_HEIGHT);
    else eff_h = EH'(cfg.image_height);
  end

  always_comb begin
    ksum_c = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ksum_c = ksum_c + KB'(coef_sel(cfg.kernel[r], 2'(c)));
      end
    end
  end

  always_ff @(posedge clk) begin
    total_r <= NW'((EW+EH)'(eff_w) * (EH+EW)'(eff_h));
    ksum_r  <= ksum_c;
  end

  // Input item holding register.
  cnv_pkg::in_item_t item_r;
  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= in_item;
  end

  // Frame position counters.
  logic [NW-1:0] n_r;
  logic [AW-1:0] wp_r;
  logic [NW-1:0] out_idx_r;
  logic [AW-1:0] ka_r;
  logic [CW-1:0] oc_r;
  logic [RW-1:0] or_r;
  logic          last_c;
  logic          col_first, col_last, row_first, row_last;

  assign last_c    = ((NW+1)'(out_idx_r) + (NW+1)'(1)) >= (NW+1)'(total_r);
  assign col_first = (oc_r == '0);
  assign col_last  = ((EW'(oc_r) + EW'(1)) == eff_w);
  assign row_first = (or_r == '0);
  assign row_last  = ((EH'(or_r) + EH'(1)) == eff_h);

  assign sts.in_frame = n_r < total_r;
  assign sts.is_flush = item_r.op;
  assign sts.produce  = ((NW+1)'(n_r) + (NW+1)'(1)) >=
                        ((NW+1)'(out_idx_r) + (NW+1)'(eff_w) + (NW+1)'(2));

  always_ff @(posedge clk) begin
    if (!rst_n || geom_wr) begin
      n_r       <= '0;
      wp_r      <= '0;
      out_idx_r <= '0;
      ka_r      <= '0;
      oc_r      <= '0;
      or_r      <= '0;
    end else begin
      if (cmd.step) begin
        n_r  <= n_r + NW'(1);
        wp_r <= (wp_r == RING_LAST) ? '0 : wp_r + AW'(1);
      end
      if (cmd.load) begin
        if (last_c) begin
          n_r       <= '0;
          wp_r      <= '0;
          out_idx_r <= '0;
          ka_r      <= '0;
          oc_r      <= '0;
          or_r      <= '0;
        end else begin
          out_idx_r <= out_idx_r + NW'(1);
          ka_r      <= (ka_r == RING_LAST) ? '0 : ka_r + AW'(1);
          if (col_last) begin
            oc_r <= '0;
            or_r <= or_r + RW'(1);
          end else begin
            oc_r <= oc_r + CW'(1);
          end
        end
      end
    end
  end

  // Tap address: ring slot of the result pixel moved by the clamped
  // row and column offsets, folded back into the ring.
  logic [AW+1:0] wx, ro, co, asum;
  logic [AW-1:0] raddr;

  always_comb begin
    wx = (AW+2)'(eff_w);
    ro = '0;
    co = '0;
    if (cmd.tap_row == 2'd0 && !row_first) ro = '0 - wx;
    if (cmd.tap_row == 2'd2 && !row_last)  ro = wx;
    if (cmd.tap_col == 2'd0 && !col_first) co = '1;
    if (cmd.tap_col == 2'd2 && !col_last)  co = (AW+2)'(1);
    asum = (AW+2)'(ka_r) + RING_X + ro + co;
    if (asum >= RING2_X)     raddr = AW'(asum - RING2_X);
    else if (asum >= RING_X) raddr = AW'(asum - RING_X);
    else                     raddr = AW'(asum);
  end

  // Line store.
  logic [NCH*PB-1:0] mem [RING];
  logic [NCH*PB-1:0] rdata_r;
  logic              wr_en;

  assign wr_en = cmd.step && sts.in_frame;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= {item_r.in_alpha, item_r.in_blue, item_r.in_green, item_r.in_red};
    end
    if (cmd.rd) rdata_r <= mem[raddr];
  end

  // Multiply-accumulate, one tap per transfer of read data.
  logic                    zero_sum;
  logic signed [CB-1:0]    coefv;
  logic signed [PB+CB:0]   prod [NCH];
  logic signed [AB-1:0]    acc_r [NCH];

  assign zero_sum = (ksum_r == '0);
  assign coefv    = coef_sel(cfg.kernel[cmd.tap_row], cmd.tap_col);

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      prod[ch] = $signed({1'b0, rdata_r[ch*PB +: PB]}) * coefv;
      if (zero_sum && prod[ch] < 0) prod[ch] = -prod[ch];
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NCH; ch++) begin
      if (cmd.step)     acc_r[ch] <= '0;
      else if (cmd.acc) acc_r[ch] <= acc_r[ch] + AB'(prod[ch]);
    end
  end

  // Divide by the kernel sum, one quotient bit per cycle. Quotients of 256
  // and above saturate, so only eight bits are developed.
  logic [KB-1:0]               dabs;
  logic [AB-1:0]               aabs [NCH];
  logic [AB:0]                 dsh [NCH];
  logic [AB-1:0]               rem_r [NCH];
  logic [cnv_pkg::QUO_BITS-1:0] quo_r [NCH];
  logic                        fix_r [NCH];
  logic [PB-1:0]               fixv_r [NCH];

  assign dabs = ksum_r[KB-1] ? KB'(-ksum_r) : KB'(ksum_r);

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      aabs[ch] = acc_r[ch][AB-1] ? AB'(-acc_r[ch]) : AB'(acc_r[ch]);
      dsh[ch]  = (AB+1)'(dabs) << cmd.bit_idx;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NCH; ch++) begin
      if (cmd.prep) begin
        rem_r[ch] <= aabs[ch];
        quo_r[ch] <= '0;
        if (zero_sum) begin
          fix_r[ch]  <= 1'b1;
          fixv_r[ch] <= (aabs[ch] > AB'(cnv_pkg::PIX_MAX)) ? cnv_pkg::PIX_MAX
                                                            : aabs[ch][PB-1:0];
        end else if (acc_r[ch] == '0 || (acc_r[ch][AB-1] != ksum_r[KB-1])) begin
          fix_r[ch]  <= 1'b1;
          fixv_r[ch] <= '0;
        end else if ((AB+1)'(aabs[ch]) >= ((AB+1)'(dabs) << cnv_pkg::QUO_BITS)) begin
          fix_r[ch]  <= 1'b1;
          fixv_r[ch] <= cnv_pkg::PIX_MAX;
        end else begin
          fix_r[ch]  <= 1'b0;
          fixv_r[ch] <= '0;
        end
      end else if (cmd.div) begin
        if ((AB+1)'(rem_r[ch]) >= dsh[ch]) begin
          rem_r[ch]              <= rem_r[ch] - AB'(dsh[ch]);
          quo_r[ch][cmd.bit_idx] <= 1'b1;
        end
      end
    end
  end

  // Output register.
  logic               out_valid_r;
  cnv_pkg::out_item_t out_data_r;
  logic [PB-1:0]      res [NCH];

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      res[ch] = fix_r[ch] ? fixv_r[ch] : quo_r[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)           out_valid_r <= 1'b0;
    else if (cmd.load)    out_valid_r <= 1'b1;
    else if (out_ready)   out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r.out_red    <= res[0];
      out_data_r.out_green  <= res[1];
      out_data_r.out_blue   <= res[2];
      out_data_r.out_alpha  <= res[3];
      out_data_r.frame_last <= last_c;
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_item     = out_data_r;

  `ASSERT_PROP(a_raddr_in_ring, clk, rst_n, cmd.rd |-> ({1'b0, raddr} < (AW+1)'(RING)))
  `ASSERT_NEVER(a_wr_rd_apart, clk, rst_n, cmd.step && cmd.rd)
  `ASSERT_PROP(a_load_slot_free, clk, rst_n, cmd.load |-> !(out_valid_r && !out_ready))

endmodule

>>> rtl/conv3x3_rgba_normalized_filter.sv
// An item is accepted only while the block is idle. For an item that
// yields a result, nine taps are read one at a time through the single
// line store read port and accumulated, the bit-serial divider develops
// the quotient and the result is loaded once the output register is free;
// only then is the next item taken. Synchronous active-low reset clears
// the frame position and result valid, and loads default size and kernel.
module conv3x3_rgba_normalized_filter #(
  parameter int MAX_WIDTH  = cnv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cnv_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cnv_stream_if.sink                 in_ch,
  cnv_stream_if.source               out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cnv_pkg::CFG_AW-1:0] paddr,
  input  logic [cnv_pkg::APB_DW-1:0] pwdata,
  output logic [cnv_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  cnv_pkg::cfg_t cfg;
  cnv_pkg::cmd_t cmd;
  cnv_pkg::sts_t sts;
  logic          geom_wr;

  cnv_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .geom_wr (geom_wr)
  );

  cnv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cnv_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .geom_wr   (geom_wr),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.data)
  );

endmodule
